FILE: design/assert_macros.svh
// Assertion macros used by the selection block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tbsm assertion failed");
`define TBSM_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define TBSM_ASSERT(lbl, clk, rst_n, prop)
`define TBSM_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif
`endif

FILE: design/tbsm_pkg.sv
// Shared constants, histogram opcodes and key helpers for the top-k selector.
`default_nettype none
package tbsm_pkg;

    localparam int          TOPK_W     = 13;
    localparam logic [12:0] TOPK_RESET = 13'd2048;
    localparam int          KEY_W      = 64;
    localparam int          POS_W      = 7;

    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK   = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_INF    = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF    = 32'hFF80_0000;

    // histogram unit commands
    localparam logic [1:0] HOP_NONE  = 2'd0;
    localparam logic [1:0] HOP_INC   = 2'd1;
    localparam logic [1:0] HOP_SCAN  = 2'd2;
    localparam logic [1:0] HOP_CLEAR = 2'd3;

    // order-preserving score bits above the inverted block index
    function automatic logic [KEY_W-1:0] make_key(input logic [31:0] bits,
                                                  input logic [31:0] idx);
        logic [31:0] u;
        u = bits[31] ? ~bits : (bits | SIGN_MASK);
        return {u, ~idx};
    endfunction

    // false for NaN and minus infinity
    function automatic logic above_neg_inf(input logic [31:0] bits);
        return ((bits & MAG_MASK) <= POS_INF) && (bits != NEG_INF);
    endfunction

endpackage
`default_nettype wire

FILE: design/tbsm_ifs.sv
// Valid/ready channel interfaces for score words in and mask words out.
`default_nettype none
interface tbsm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_score_bits;
    logic        last_block;

    modport source (output valid, output block_score_bits, output last_block, input ready);
    modport sink   (input valid, input block_score_bits, input last_block, output ready);
endinterface

interface tbsm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] keep_mask;
    logic [5:0]  word_index;
    logic        overflow;
    logic        last_word;

    modport source (output valid, output keep_mask, output word_index, output overflow,
                    output last_word, input ready);
    modport sink   (input valid, input keep_mask, input word_index, input overflow,
                    input last_word, output ready);
endinterface
`default_nettype wire

FILE: design/topk_block_select_mask_unit.sv
// Top level: row store, radix-select sequencer and keep-mask emitter.
//
// score_in takes one float32 score word per cycle while the unit is loading;
// last_block closes the row. Scores beyond MAX_BLOCKS are dropped and the row
// is flagged. mask_out then delivers ceil(n/64) keep-mask words in order of
// word_index, last_word on the final one. cfg_wr_en/cfg_wr_data set the keep count K.
//
// For a row of n stored scores: when 0 < K < n, the K-th largest key is found by
// ceil(64/RADIX_BITS) passes, each a scan of the score memory (one read per cycle)
// and a top-down sweep of the digit histogram memory. The mask is then rebuilt
// from the score memory word by word. The single read port of the score memory
// sets the pace of the scan and mask phases. After reset the histogram memory is
// swept to zero before the first score word is taken. A stalled receiver holds
// the output word; the unit finishes the next word and waits, and returns to
// loading as soon as the final word sits in the output register.
`default_nettype none
`include "assert_macros.svh"
module topk_block_select_mask_unit import tbsm_pkg::*; #(
    parameter int MAX_BLOCKS = 4096,
    parameter int RADIX_BITS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_wr_en,
    input  wire logic [TOPK_W-1:0] cfg_wr_data,
    tbsm_in_if.sink    score_in,
    tbsm_out_if.source mask_out
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int R  = RADIX_BITS;
    localparam int BW = $clog2(RADIX_BITS + 1);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_PASS  = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_HSCAN = 4'd4;
    localparam logic [3:0] ST_HFIN  = 4'd5;
    localparam logic [3:0] ST_MASK  = 4'd6;
    localparam logic [3:0] ST_MWAIT = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ALL  = 2'd1;
    localparam logic [1:0] MODE_KTH  = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [TOPK_W-1:0] topk_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              row_ovf_reg, row_ovf_next;
    logic [1:0]        mode_reg, mode_next;
    logic [CW-1:0]     rank_reg, rank_next;
    logic [CW-1:0]     cum_reg, cum_next;
    logic              found_reg, found_next;
    logic [R-1:0]      digit_reg, digit_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BW-1:0]     bits_reg, bits_next;
    logic [KEY_W-1:0]  kp_reg, kp_next;
    logic [KEY_W-1:0]  hm_reg, hm_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [R-1:0]      haddr_reg, haddr_next;
    logic              s1_v_reg, s1_v_next;
    logic              s1_pass_reg, s1_pass_next;
    logic [AW-1:0]     s1_idx_reg;
    logic [5:0]        s1_bit_reg;
    logic [5:0]        word_reg, word_next;
    logic [5:0]        bit_reg, bit_next;
    logic [63:0]       acc_reg, acc_next;
    logic              lastw_reg, lastw_next;
    logic              out_v_reg, out_v_next;
    logic [63:0]       out_mask_reg;
    logic [5:0]        out_idx_reg;
    logic              out_ovf_reg, out_last_reg;

    logic              accept, full, emit_go, hit;
    logic [CW-1:0]     n_close;
    logic [TOPK_W-1:0] k_wide;
    logic [CW-1:0]     k_close;
    logic [AW-1:0]     raddr;
    logic [31:0]       rdata;
    logic [KEY_W-1:0]  key;
    logic [R-1:0]      dmask, key_digit, fin_digit;
    logic              key_match, keep;
    logic [CW:0]       sum;
    logic [12:0]       b_ext;
    logic [BW-1:0]     nb;
    logic [1:0]        hop;
    logic [R-1:0]      haddr_cmd;
    logic              hist_rsp_valid, hist_busy;
    logic [R-1:0]      hist_rsp_addr;
    logic [CW-1:0]     hist_rsp_count;

    assign accept = score_in.valid && score_in.ready;
    assign full   = (count_reg == CW'(MAX_BLOCKS));

    tbsm_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_scores (
        .clk   (clk),
        .we    (accept && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (score_in.block_score_bits),
        .raddr (raddr),
        .rdata (rdata)
    );

    tbsm_hist #(.R(R), .CW(CW)) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_op    (hop),
        .cmd_addr  (haddr_cmd),
        .rsp_valid (hist_rsp_valid),
        .rsp_addr  (hist_rsp_addr),
        .rsp_count (hist_rsp_count),
        .busy      (hist_busy)
    );

    always_comb
    begin
        // key of the score word returning from memory
        dmask     = R'((32'd1 << bits_reg) - 32'd1);
        key       = make_key(rdata, 32'(s1_idx_reg));
        key_match = ((key ^ kp_reg) & hm_reg) == '0;
        key_digit = R'(key >> pos_reg) & dmask;
        unique case (mode_reg)
            MODE_ALL: keep = above_neg_inf(rdata);
            MODE_KTH: keep = (key >= kp_reg) && above_neg_inf(rdata);
            default:  keep = 1'b0;
        endcase

        // histogram sweep: first digit whose running count reaches the rank
        sum       = {1'b0, cum_reg} + {1'b0, hist_rsp_count};
        hit       = hist_rsp_valid && !found_reg && (sum >= {1'b0, rank_reg});
        fin_digit = hit ? hist_rsp_addr : digit_reg;

        n_close = full ? count_reg : count_reg + CW'(1);
        k_wide  = (topk_reg < TOPK_W'(n_close)) ? topk_reg : TOPK_W'(n_close);
        k_close = CW'(k_wide);
        b_ext   = 13'({word_reg, bit_reg});
        nb      = (pos_reg < POS_W'(R)) ? BW'(pos_reg) : BW'(R);
        emit_go = !out_v_reg || mask_out.ready;

        hop       = HOP_NONE;
        haddr_cmd = haddr_reg;
        if (state_reg == ST_CLR)
        begin
            hop = HOP_CLEAR;
        end
        else if (state_reg == ST_HSCAN)
        begin
            hop = HOP_SCAN;
        end
        else if (s1_v_reg && s1_pass_reg && key_match)
        begin
            hop       = HOP_INC;
            haddr_cmd = key_digit;
        end

        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        row_ovf_next = row_ovf_reg;
        mode_next    = mode_reg;
        rank_next    = rank_reg;
        cum_next     = cum_reg;
        found_next   = found_reg;
        digit_next   = digit_reg;
        pos_next     = pos_reg;
        bits_next    = bits_reg;
        kp_next      = kp_reg;
        hm_next      = hm_reg;
        idx_next     = idx_reg;
        haddr_next   = haddr_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        lastw_next   = lastw_reg;
        raddr        = idx_reg;
        s1_v_next    = 1'b0;
        s1_pass_next = 1'b1;
        acc_next     = acc_reg;
        out_v_next   = out_v_reg && !mask_out.ready;

        if (s1_v_reg && !s1_pass_reg && keep)
        begin
            acc_next = acc_reg | (64'd1 << s1_bit_reg);
        end

        if (hit)
        begin
            found_next = 1'b1;
            digit_next = hist_rsp_addr;
            rank_next  = rank_reg - cum_reg;
        end
        else if (hist_rsp_valid && !found_reg)
        begin
            cum_next = CW'(sum);
        end

        unique case (state_reg)
            ST_CLR:
            begin
                haddr_next = haddr_reg + R'(1);
                if (haddr_reg == '1)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (score_in.last_block)
                    begin
                        // close the row: snapshot count, flag and K
                        n_next       = n_close;
                        row_ovf_next = ovf_reg || full;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        word_next    = '0;
                        bit_next     = '0;
                        lastw_next   = 1'b0;
                        acc_next     = '0;
                        idx_next     = '0;
                        if (k_close == '0)
                        begin
                            mode_next  = MODE_NONE;
                            state_next = ST_MASK;
                        end
                        else if (k_close >= n_close)
                        begin
                            mode_next  = MODE_ALL;
                            state_next = ST_MASK;
                        end
                        else
                        begin
                            mode_next  = MODE_KTH;
                            rank_next  = k_close;
                            cum_next   = '0;
                            found_next = 1'b0;
                            kp_next    = '0;
                            hm_next    = '0;
                            bits_next  = BW'(R);
                            pos_next   = POS_W'(KEY_W - R);
                            state_next = ST_PASS;
                        end
                    end
                end
            end
            ST_PASS:
            begin
                s1_v_next = 1'b1;
                idx_next  = idx_reg + AW'(1);
                if (CW'(idx_reg) + CW'(1) == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last increment to land in the histogram
                if (!s1_v_reg && !hist_busy)
                begin
                    haddr_next = dmask;
                    state_next = ST_HSCAN;
                end
            end
            ST_HSCAN:
            begin
                haddr_next = haddr_reg - R'(1);
                if (haddr_reg == '0)
                begin
                    state_next = ST_HFIN;
                end
            end
            ST_HFIN:
            begin
                kp_next = kp_reg | (64'(fin_digit) << pos_reg);
                hm_next = hm_reg | (64'(dmask) << pos_reg);
                if (pos_reg == '0)
                begin
                    state_next = ST_MASK;
                end
                else
                begin
                    bits_next  = nb;
                    pos_next   = pos_reg - POS_W'(nb);
                    cum_next   = '0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_PASS;
                end
            end
            ST_MASK:
            begin
                raddr        = AW'({word_reg, bit_reg});
                s1_v_next    = 1'b1;
                s1_pass_next = 1'b0;
                bit_next     = bit_reg + 6'd1;
                if (b_ext + 13'd1 == 13'(n_reg))
                begin
                    lastw_next = 1'b1;
                    state_next = ST_MWAIT;
                end
                else if (bit_reg == 6'd63)
                begin
                    state_next = ST_MWAIT;
                end
            end
            ST_MWAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_v_next = 1'b1;
                    acc_next   = '0;
                    word_next  = word_reg + 6'd1;
                    bit_next   = '0;
                    state_next = lastw_reg ? ST_LOAD : ST_MASK;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            topk_reg  <= TOPK_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            haddr_reg <= '0;
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                topk_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            haddr_reg <= haddr_next;
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        row_ovf_reg <= row_ovf_next;
        mode_reg    <= mode_next;
        rank_reg    <= rank_next;
        cum_reg     <= cum_next;
        found_reg   <= found_next;
        digit_reg   <= digit_next;
        pos_reg     <= pos_next;
        bits_reg    <= bits_next;
        kp_reg      <= kp_next;
        hm_reg      <= hm_next;
        idx_reg     <= idx_next;
        s1_pass_reg <= s1_pass_next;
        s1_idx_reg  <= raddr;
        s1_bit_reg  <= bit_reg;
        word_reg    <= word_next;
        bit_reg     <= bit_next;
        acc_reg     <= acc_next;
        lastw_reg   <= lastw_next;
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_mask_reg <= acc_reg;
            out_idx_reg  <= word_reg;
            out_ovf_reg  <= row_ovf_reg;
            out_last_reg <= lastw_reg;
        end
    end

    assign score_in.ready      = (state_reg == ST_LOAD);
    assign mask_out.valid      = out_v_reg;
    assign mask_out.keep_mask  = out_mask_reg;
    assign mask_out.word_index = out_idx_reg;
    assign mask_out.overflow   = out_ovf_reg;
    assign mask_out.last_word  = out_last_reg;

    `TBSM_ASSERT(a_rsp_in_scan, clk, rst_n, hist_rsp_valid |-> (state_reg == ST_HSCAN || state_reg == ST_HFIN))
    `TBSM_ASSERT(a_digit_found, clk, rst_n, (state_reg == ST_HFIN) |-> (found_reg || hit))
    `TBSM_ASSERT(a_scan_drained, clk, rst_n, (state_reg == ST_HSCAN) |-> !s1_v_reg)
    `TBSM_ASSERT_MSG(a_last_reloads, clk, rst_n, (state_reg == ST_EMIT && emit_go && lastw_reg) |=> (state_reg == ST_LOAD), "row did not return to loading")
endmodule
`default_nettype wire

FILE: design/tbsm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module tbsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: design/tbsm_hist.sv
// Digit histogram: read-modify-write counter memory with one-deep forwarding.
`default_nettype none
module tbsm_hist import tbsm_pkg::*; #(
    parameter int R  = 8,
    parameter int CW = 13
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    cmd_op,
    input  wire logic [R-1:0]  cmd_addr,
    output logic               rsp_valid,
    output logic [R-1:0]       rsp_addr,
    output logic [CW-1:0]      rsp_count,
    output logic               busy
);
    logic [1:0]    pend_op_reg, pend_op_next;
    logic [R-1:0]  pend_addr_reg;
    logic          lw_v_reg, lw_v_next;
    logic [R-1:0]  lw_addr_reg;
    logic [CW-1:0] lw_data_reg;
    logic          we;
    logic [R-1:0]  waddr;
    logic [CW-1:0] wdata;
    logic [CW-1:0] rdata;
    logic [CW-1:0] base;

    tbsm_ram #(.WIDTH(CW), .DEPTH(1 << R)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cmd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        base      = (lw_v_reg && (lw_addr_reg == pend_addr_reg)) ? lw_data_reg : rdata;
        we        = 1'b0;
        waddr     = cmd_addr;
        wdata     = '0;
        lw_v_next = 1'b0;
        unique case (pend_op_reg)
            HOP_INC:
            begin
                we        = 1'b1;
                waddr     = pend_addr_reg;
                wdata     = base + CW'(1);
                lw_v_next = 1'b1;
            end
            HOP_SCAN:
            begin
                // clear behind the scan so the next pass starts from zero
                we    = 1'b1;
                waddr = pend_addr_reg;
            end
            default:
            begin
                we = (cmd_op == HOP_CLEAR);
            end
        endcase
        pend_op_next = ((cmd_op == HOP_INC) || (cmd_op == HOP_SCAN)) ? cmd_op : HOP_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_op_reg <= HOP_NONE;
            lw_v_reg    <= 1'b0;
        end
        else
        begin
            pend_op_reg <= pend_op_next;
            lw_v_reg    <= lw_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cmd_addr;
        lw_addr_reg   <= waddr;
        lw_data_reg   <= wdata;
    end

    assign rsp_valid = (pend_op_reg == HOP_SCAN);
    assign rsp_addr  = pend_addr_reg;
    assign rsp_count = rdata;
    assign busy      = (pend_op_reg != HOP_NONE);
endmodule
`default_nettype wire

FILE: dv/topk_block_select_mask_unit_tb.sv
// Self-checking testbench for the top-k block select mask unit.
`default_nettype none
module topk_block_select_mask_unit_tb;
    import tbsm_pkg::*;

    localparam int ROW_MAX     = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [63:0] keep_mask;
        logic [5:0]  word_index;
        logic        overflow;
        logic        last_word;
    } mask_word_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [TOPK_W-1:0] cfg_wr_data;

    tbsm_in_if  score_if ();
    tbsm_out_if mask_if ();

    topk_block_select_mask_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .score_in    (score_if),
        .mask_out    (mask_if)
    );

    // Shadow of the unit: current row, topk setting and pending mask words
    logic [31:0]  row_scores [ROW_MAX];
    int           row_n;
    logic         row_ovf;
    logic [12:0]  topk_now;
    mask_word_t   pending_words [$];
    logic [31:0]  prev_score;

    int src_idle_pct;
    int snk_stall_pct;
    int error_count;
    int words_checked;
    int scores_sent;
    int rows_closed;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Order-preserving key: flipped float bits above the inverted index
    function automatic logic [63:0] order_key(logic [31:0] bits, int idx);
        logic [31:0] u;
        logic [31:0] pos;
        pos = idx;
        u = bits[31] ? ~bits : {1'b1, bits[30:0]};
        return {u, ~pos};
    endfunction

    // NaN and minus infinity are never kept
    function automatic logic keepable(logic [31:0] bits);
        if (bits[30:0] > 31'h7F80_0000)
            return 1'b0;
        return bits != 32'hFF80_0000;
    endfunction

    // Close the row: rank each block against the rest where K cuts the row, and queue the words
    task automatic close_row();
        int k;
        int words;
        int rank;
        int b;
        mask_word_t w;
        logic [63:0] kb;
        k = (topk_now < row_n) ? int'(topk_now) : row_n;
        words = (row_n + 63) / 64;
        for (int wi = 0; wi < words; wi++)
        begin
            w = '0;
            w.word_index = wi[5:0];
            w.overflow   = row_ovf;
            w.last_word  = (wi == words - 1);
            for (int j = 0; j < 64; j++)
            begin
                b = wi * 64 + j;
                if (b < row_n && k > 0 && keepable(row_scores[b]))
                begin
                    if (k >= row_n)
                        w.keep_mask[j] = 1'b1;
                    else
                    begin
                        // kept when fewer than K keys lie above it
                        rank = 0;
                        kb = order_key(row_scores[b], b);
                        for (int i = 0; i < row_n && rank < k; i++)
                            if (order_key(row_scores[i], i) > kb)
                                rank++;
                        w.keep_mask[j] = (rank < k);
                    end
                end
            end
            pending_words.push_back(w);
        end
        row_n   = 0;
        row_ovf = 1'b0;
        rows_closed++;
    endtask

    // Send one score word; hold valid across back-to-back words
    task automatic send_score(logic [31:0] bits, logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            score_if.valid <= 1'b0;
            @(posedge clk);
        end
        score_if.valid            <= 1'b1;
        score_if.block_score_bits <= bits;
        score_if.last_block       <= last;
        do
            @(posedge clk);
        while (!score_if.ready);
        scores_sent++;
        if (row_n < ROW_MAX)
        begin
            row_scores[row_n] = bits;
            row_n++;
        end
        else
            row_ovf = 1'b1;
        prev_score = bits;
        if (last)
            close_row();
    endtask

    task automatic drop_valid();
        score_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write topk only once the unit has drained; drop valid so no word is resent
    task automatic write_topk(logic [12:0] value);
        score_if.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        topk_now = value;
    endtask

    function automatic logic [31:0] rand_score();
        case ($urandom_range(11))
            0: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
            1: return NEG_INF;
            2: return POS_INF;
            3: return {1'($urandom_range(1)), 31'd0};
            4, 5: return prev_score;
            6: return {1'($urandom_range(1)), 8'h7F, 23'($urandom_range(3))};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_row(int len);
        for (int i = 0; i < len; i++)
            send_score(rand_score(), i == len - 1);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    // Receiver: random stall, then compare each accepted word with the oldest one queued
    always @(posedge clk)
    begin
        mask_word_t want;
        if (rst_n)
        begin
            if (mask_if.valid && mask_if.ready)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("unexpected word", mask_if.keep_mask, '0);
                else
                begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (mask_if.keep_mask != want.keep_mask)
                        report_mismatch("keep_mask", mask_if.keep_mask, want.keep_mask);
                    if (mask_if.word_index != want.word_index)
                        report_mismatch("word_index", mask_if.word_index, want.word_index);
                    if (mask_if.overflow != want.overflow)
                        report_mismatch("overflow", mask_if.overflow, want.overflow);
                    if (mask_if.last_word != want.last_word)
                        report_mismatch("last_word", mask_if.last_word, want.last_word);
                end
            end
            mask_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_specials();
        // NaN, infinities, signed zeros and a tie, with topk cutting through them
        logic [31:0] vals [12] = '{32'h7FC0_0000, POS_INF, NEG_INF, 32'h0000_0000,
                                   32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000,
                                   32'hBF80_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
                                   32'hFF7F_FFFF, 32'h0000_0001};
        foreach (vals[i])
        begin
            write_topk(13'(i + 1));
            for (int j = 0; j < 12; j++)
                send_score(vals[j], j == 11);
            drop_valid();
        end
        write_topk(13'd0);
        for (int j = 0; j < 12; j++)
            send_score(vals[j], j == 11);
        write_topk(13'd8191);
        send_score(32'h4000_0000, 1'b1);
        send_score(NEG_INF, 1'b1);
        drop_valid();
    endtask

    task automatic test_word_edges();
        // rows that fill one word exactly, then spill into a second and a third
        write_topk(13'd1);
        send_row(64);
        write_topk(13'd63);
        send_row(65);
        write_topk(13'd64);
        send_row(129);
        drop_valid();
    endtask

    task automatic test_overflow();
        // two blocks past the store, the last dropped one closing the row
        write_topk(13'd4096);
        send_row(ROW_MAX + 2);
        drop_valid();
        write_topk(13'd3000);
        send_row(300);
        drop_valid();
    endtask

    task automatic test_random_phase(int idle, int stall, int budget);
        int sent;
        int len;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(2) == 0)
                case ($urandom_range(6))
                    0: write_topk(13'd0);
                    1: write_topk(13'd1);
                    2: write_topk(13'd4096);
                    3: write_topk(13'd8191);
                    default: write_topk(13'($urandom_range(1, 80)));
                endcase
            len = ($urandom_range(15) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 70);
            send_row(len);
            sent += len;
            if ($urandom_range(1))
                drop_valid();
        end
        drop_valid();
    endtask

    initial
    begin
        rst_n                     = 1'b0;
        cfg_wr_en                 = 1'b0;
        cfg_wr_data               = '0;
        score_if.valid            = 1'b0;
        score_if.block_score_bits = '0;
        score_if.last_block       = 1'b0;
        mask_if.ready             = 1'b0;
        topk_now                  = TOPK_RESET;
        row_n                     = 0;
        row_ovf                   = 1'b0;
        prev_score                = '0;
        src_idle_pct              = 0;
        snk_stall_pct             = 0;
        error_count               = 0;
        words_checked             = 0;
        scores_sent               = 0;
        rows_closed               = 0;
        cycle_count               = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of topk in force for the first row
        send_row(20);
        drop_valid();
        test_specials();
        test_word_edges();
        test_overflow();
        test_random_phase(0, 0, 120);
        test_random_phase(53, 0, 120);
        test_random_phase(0, 53, 120);
        test_random_phase(32, 32, 120);

        wait (pending_words.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d score words in %0d rows, %0d mask words checked,",
                 scores_sent, rows_closed, words_checked);
        $display("with topk extremes, special floats, ties, word edges and store overflow.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
